FILE: src/pid_antiwindup_controller_macros.svh
// assertion macros for the pid controller port checker
`ifndef PID_ANTIWINDUP_CONTROLLER_MACROS_SVH
`define PID_ANTIWINDUP_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PIDAW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidaw check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PIDAW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidaw check failed");

`endif

FILE: src/pidaw_pkg.sv
// shared constants, types and saturation helpers for the pid controller
`timescale 1ns / 1ps

package pidaw_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = DATA_W + 2;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_GAIN_PROP  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_GAIN_INTEG = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_GAIN_DERIV = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_DRIVE_MIN  = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_DRIVE_MAX  = CFG_AW'(4);

  localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = DATA_W'(1 << FRAC_W);
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -DRIVE_MAX_RST;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {3'b000, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {3'b111, {(DATA_W-1){1'b0}}};

  // request into the serial divider
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [PROD_W-1:0] num;
    logic [DATA_W-2:0] den;
  } div_req_t;

  // status and result out of the serial divider
  typedef struct packed {
    logic                     busy;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

  // magnitude of a signed word, most negative value maps to 2^(w-1)
  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

  // saturate a sign and magnitude pair to the signed data range
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                      input logic [PROD_W-1:0] m);
    logic [PROD_W-1:0] lim;
    logic [PROD_W-1:0] v;
    logic [DATA_W-1:0] vs;
    lim = {{(PROD_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}} - PROD_W'(!neg);
    v   = (m > lim) ? lim : m;
    vs  = v[DATA_W-1:0];
    return neg ? -vs : vs;
  endfunction

  // saturate a widened sum to the signed data range
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] c;
    c = s;
    if (s > SUM_MAX) c = SUM_MAX;
    else if (s < SUM_MIN) c = SUM_MIN;
    return c[DATA_W-1:0];
  endfunction

  // saturated sum of three signed words
  function automatic logic signed [DATA_W-1:0] add3(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b,
                                                   input logic signed [DATA_W-1:0] c);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    return sat_sum(s);
  endfunction

  // saturated difference of two signed words
  function automatic logic signed [DATA_W-1:0] sub2(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) - SUM_W'(b);
    return sat_sum(s);
  endfunction

endpackage

FILE: src/pid_antiwindup_controller.sv
// pid controller with conditional-integration anti-windup, top level
`timescale 1ns / 1ps

// usage
// - input stream in_*: one transaction per sample, tdata carries target,
//   sensed and step_time, all signed Q16.16
// - output stream out_*: one transaction per sample with the clamped drive
//   and the three terms; tuser flags held and frozen
// - cfg_*: write-only register port (gains and drive limits), written while idle
// - in_tready is high only while the sequencer is idle, so one sample is in
//   work at a time; a sample with step_time <= 0 skips the arithmetic and goes
//   straight to the output step; an active sample spends most of its time in the
//   32-step serial divide of the derivative term (one quotient bit per cycle),
//   which is skipped when the derivative quotient overflows and saturates at once
// - the four products go one after another through a single multiplier
// - a finished result sits in the output register; the next sample is taken
//   while it waits, and the sequencer stalls at its last step if the receiver
//   still holds the previous result
// - synchronous reset clears the integrator, the held terms, the seed flag
//   and restores the default gains (0) and limits (-1.0, +1.0)

module pid_antiwindup_controller (
  input  logic        clk,
  input  logic        rst_n,
  // target[31:0], sensed[63:32], step_time[95:64]
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // drive[31:0], prop_part[63:32], integ_part[95:64], deriv_part[127:96]
  output logic [127:0] out_tdata,
  // held[0], frozen[1]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [pidaw_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pidaw_pkg::DATA_W-1:0] cfg_wdata
);

  localparam int DW = pidaw_pkg::DATA_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ERR  = 9'b000000010,
    ST_MP   = 9'b000000100,
    ST_MI   = 9'b000001000,
    ST_MD   = 9'b000010000,
    ST_MT   = 9'b000100000,
    ST_WAIT = 9'b001000000,
    ST_SUM  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  // configuration
  logic signed [DW-1:0] kp_r, ki_r, kd_r, dmin_r, dmax_r;

  // sample and working values
  logic signed [DW-1:0] tgt_r, sen_r, dt_r, err_r, diff_r, ki_err_r, next_r;
  logic signed [DW-1:0] last_r, integ_acc_r;
  logic signed [DW-1:0] prop_hold_r, integ_hold_r, deriv_hold_r;
  logic                 seeded_r, held_r, frz_r;

  // output register
  logic [127:0] out_data_r;
  logic [1:0]   out_user_r;
  logic         out_valid_r;

  // multiplier hookup
  logic                 mul_go;
  logic signed [DW-1:0] mul_a, mul_b, mul_q;
  logic [pidaw_pkg::PROD_W-1:0] mul_prod;
  logic                 mul_neg;

  pidaw_pkg::div_req_t div_req;
  pidaw_pkg::div_rsp_t div_rsp;

  logic                 in_acc, out_free, dt_hold;
  logic signed [DW-1:0] last_eff, sum_try, sum_fin, drv;
  logic                 frz_now;

  assign in_tready = rst_n && (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign dt_hold   = in_tdata[95] || (in_tdata[95:64] == '0);

  // first active sample after reset uses its own measurement as history
  assign last_eff = seeded_r ? last_r : sen_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_go = 1'b0;
    mul_a  = kp_r;
    mul_b  = err_r;
    unique case (st_r)
      ST_MP: begin
        mul_go = 1'b1;
      end
      ST_MI: begin
        mul_go = 1'b1;
        mul_a  = ki_r;
      end
      ST_MD: begin
        mul_go = 1'b1;
        mul_a  = kd_r;
        mul_b  = diff_r;
      end
      ST_MT: begin
        mul_go = 1'b1;
        mul_a  = ki_err_r;
        mul_b  = dt_r;
      end
      default: ;
    endcase
  end

  pidaw_mul u_mul (
    .clk    (clk),
    .go     (mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_prod),
    .neg_r  (mul_neg),
    .q_sat  (mul_q)
  );

  // derivative: -(kd * diff) / dt in raw units, started off the kd*diff product
  assign div_req.start = (st_r == ST_MT);
  assign div_req.neg   = !mul_neg;
  assign div_req.num   = mul_prod;
  assign div_req.den   = dt_r[DW-2:0];

  pidaw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // tentative sum with the new integrator, and the anti-windup decision
  assign sum_try = pidaw_pkg::add3(prop_hold_r, next_r, deriv_hold_r);
  assign frz_now = ((sum_try > dmax_r) && !err_r[DW-1] && (err_r != '0)) ||
                   ((sum_try < dmin_r) && err_r[DW-1]);

  // final sum from the committed terms, then the drive clamp
  assign sum_fin = pidaw_pkg::add3(prop_hold_r, integ_hold_r, deriv_hold_r);

  always_comb begin
    priority if (sum_fin < dmin_r) drv = dmin_r;
    else if (sum_fin > dmax_r)     drv = dmax_r;
    else                           drv = sum_fin;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = dt_hold ? ST_FIN : ST_ERR;
      ST_ERR:  st_nxt = ST_MP;
      ST_MP:   st_nxt = ST_MI;
      ST_MI:   st_nxt = ST_MD;
      ST_MD:   st_nxt = ST_MT;
      ST_MT:   st_nxt = ST_WAIT;
      ST_WAIT: if (!div_rsp.busy) st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_FIN;
      ST_FIN:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      dmin_r       <= pidaw_pkg::DRIVE_MIN_RST;
      dmax_r       <= pidaw_pkg::DRIVE_MAX_RST;
      seeded_r     <= 1'b0;
      last_r       <= '0;
      integ_acc_r  <= '0;
      prop_hold_r  <= '0;
      integ_hold_r <= '0;
      deriv_hold_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          pidaw_pkg::REG_GAIN_PROP:  kp_r   <= cfg_wdata;
          pidaw_pkg::REG_GAIN_INTEG: ki_r   <= cfg_wdata;
          pidaw_pkg::REG_GAIN_DERIV: kd_r   <= cfg_wdata;
          pidaw_pkg::REG_DRIVE_MIN:  dmin_r <= cfg_wdata;
          pidaw_pkg::REG_DRIVE_MAX:  dmax_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (st_r == ST_ERR) begin
        seeded_r <= 1'b1;
        last_r   <= sen_r;
      end
      if (st_r == ST_MI) prop_hold_r <= mul_q;
      if ((st_r == ST_WAIT) && !div_rsp.busy) deriv_hold_r <= div_rsp.quot;
      if (st_r == ST_SUM) begin
        // refused step keeps the old integrator
        if (!frz_now) begin
          integ_acc_r  <= next_r;
          integ_hold_r <= next_r;
        end else begin
          integ_hold_r <= integ_acc_r;
        end
      end
      if ((st_r == ST_FIN) && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r  <= in_tdata[DW-1:0];
      sen_r  <= in_tdata[2*DW-1:DW];
      dt_r   <= in_tdata[3*DW-1:2*DW];
      held_r <= dt_hold;
      frz_r  <= 1'b0;
    end
    if (st_r == ST_ERR) begin
      err_r  <= pidaw_pkg::sub2(tgt_r, sen_r);
      diff_r <= pidaw_pkg::sub2(sen_r, last_eff);
    end
    if (st_r == ST_MD) ki_err_r <= mul_q;
    if ((st_r == ST_WAIT) && !div_rsp.busy) begin
      next_r <= pidaw_pkg::add3(integ_acc_r, mul_q, '0);
    end
    if (st_r == ST_SUM) frz_r <= frz_now;
    if ((st_r == ST_FIN) && out_free) begin
      out_data_r <= {deriv_hold_r, integ_hold_r, prop_hold_r, drv};
      out_user_r <= {frz_r, held_r};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

endmodule

FILE: src/pidaw_mul.sv
// shared sign-magnitude multiplier with registered product
`timescale 1ns / 1ps

module pidaw_mul (
  input  logic                             clk,
  input  logic                             go,
  input  logic signed [pidaw_pkg::DATA_W-1:0] a,
  input  logic signed [pidaw_pkg::DATA_W-1:0] b,
  output logic        [pidaw_pkg::PROD_W-1:0] prod_r,
  output logic                             neg_r,
  output logic signed [pidaw_pkg::DATA_W-1:0] q_sat
);

  logic [pidaw_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = pidaw_pkg::PROD_W'(pidaw_pkg::mag(a)) *
                    pidaw_pkg::PROD_W'(pidaw_pkg::mag(b));

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= prod_nxt;
      neg_r  <= a[pidaw_pkg::DATA_W-1] ^ b[pidaw_pkg::DATA_W-1];
    end
  end

  // fixed-point product: drop the fraction bits, truncate toward zero
  assign q_sat = pidaw_pkg::sat_mag(neg_r, prod_r >> pidaw_pkg::FRAC_W);

endmodule

FILE: src/pidaw_div.sv
// restoring divider, one quotient bit per cycle, saturated signed result
`timescale 1ns / 1ps

module pidaw_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pidaw_pkg::div_req_t req,
  output pidaw_pkg::div_rsp_t rsp
);

  localparam int DW    = pidaw_pkg::DATA_W;
  localparam int CNT_W = $clog2(DW);

  logic            busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-2:0]   rem_r;
  logic [DW-1:0]   num_r;
  logic [DW-1:0]   q_r;
  logic [DW-2:0]   den_r;
  logic            ovf_r;
  logic            neg_r;

  logic [DW-1:0]   rem_sh;
  logic            ge;
  logic [DW-1:0]   rem_nxt;
  logic            ovf_nxt;

  assign rem_sh  = {rem_r, num_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  // quotient needs more than DW bits when the high half already reaches den
  assign ovf_nxt = req.num[pidaw_pkg::PROD_W-1:DW] >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= !ovf_nxt;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[DW +: DW-1];
      num_r <= req.num[DW-1:0];
      q_r   <= '0;
      den_r <= req.den;
      ovf_r <= ovf_nxt;
      neg_r <= req.neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DW-2:0];
      num_r <= {num_r[DW-2:0], 1'b0};
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = pidaw_pkg::sat_mag(neg_r, ovf_r ? {pidaw_pkg::PROD_W{1'b1}} :
                                              pidaw_pkg::PROD_W'(q_r));

endmodule

FILE: src/pidaw_chk.sv
// port-level checker for the pid controller, bound to the top level
`timescale 1ns / 1ps
`include "pid_antiwindup_controller_macros.svh"

module pidaw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic [95:0] in_tdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        cfg_we,
  input logic [pidaw_pkg::CFG_AW-1:0] cfg_addr,
  input logic [pidaw_pkg::DATA_W-1:0] cfg_wdata
);

  // one sample at a time: ready drops right after a transaction
  `PIDAW_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a result never shows up in the cycle right after its sample
  `PIDAW_ASSERT_NXT(a_no_instant_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid)

  // a held sample never reports a refused integrator step
  `PIDAW_ASSERT_IMP(a_held_not_frozen, out_tvalid, !(out_tuser[0] && out_tuser[1]))

  // a stalled result stays put
  `PIDAW_ASSERT_NXT(a_out_stall_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind pid_antiwindup_controller pidaw_chk u_pidaw_chk (.*);

FILE: dv/pid_antiwindup_checker.sv
// checker for the pid controller: predicts every sample's result and compares it
`timescale 1ns / 1ps

module pid_antiwindup_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [95:0]                    in_tdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [127:0]                   out_tdata,
  input  logic [1:0]                     out_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [pidaw_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pidaw_pkg::DATA_W-1:0]   cfg_wdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_seen,
  output int                             held_seen,
  output int                             frozen_seen
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] drive;
    logic [31:0] prop;
    logic [31:0] integ;
    logic [31:0] deriv;
    logic        held;
    logic        frozen;
  } pid_result_t;

  // configuration copy
  longint kp, ki, kd, lim_lo, lim_hi;
  // controller state copy
  longint acc, prev_sensed, p_keep, i_keep, d_keep;
  bit     have_seed;

  pid_result_t queued_drives[$];
  pid_result_t want, got;
  int errs = 0;
  int n_res = 0;
  int n_held = 0;
  int n_frz = 0;

  function automatic longint clip(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  // sign and magnitude back to a saturated word
  function automatic longint signed_limit(bit neg, longint unsigned m);
    longint unsigned lim;
    longint unsigned v;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    v = (m > lim) ? lim : m;
    return neg ? -$signed(v) : $signed(v);
  endfunction

  // fixed-point product, truncated toward zero
  function automatic longint qmul(longint a, longint b);
    longint unsigned p;
    p = magnitude(a) * magnitude(b);
    return signed_limit((a < 0) != (b < 0), p >> pidaw_pkg::FRAC_W);
  endfunction

  function automatic longint clamp_to_limits(longint v);
    if (v < lim_lo) return lim_lo;
    if (v > lim_hi) return lim_hi;
    return v;
  endfunction

  function automatic pid_result_t compute_drive(input logic [95:0] smp);
    longint tgt, sen, dt, err, diff, nxt, sum;
    longint unsigned q;
    bit frz;
    pid_result_t r;
    tgt = $signed(smp[31:0]);
    sen = $signed(smp[63:32]);
    dt  = $signed(smp[95:64]);
    if (dt <= 0) begin
      sum = clip(p_keep + i_keep + d_keep);
      r.drive  = 32'(clamp_to_limits(sum));
      r.prop   = 32'(p_keep);
      r.integ  = 32'(i_keep);
      r.deriv  = 32'(d_keep);
      r.held   = 1'b1;
      r.frozen = 1'b0;
      return r;
    end
    err = clip(tgt - sen);
    if (!have_seed) begin
      prev_sensed = sen;
      have_seed = 1'b1;
    end
    p_keep = qmul(kp, err);
    // derivative on measurement, exact in raw units, one truncation
    diff = clip(sen - prev_sensed);
    q = (magnitude(kd) * magnitude(diff)) / dt;
    d_keep = signed_limit((kd < 0) == (diff < 0), q);
    prev_sensed = sen;
    nxt = clip(acc + qmul(qmul(ki, err), dt));
    sum = clip(p_keep + nxt + d_keep);
    frz = (sum > lim_hi && err > 0) || (sum < lim_lo && err < 0);
    if (!frz) begin
      acc = nxt;
      i_keep = nxt;
    end else begin
      i_keep = acc;
      sum = clip(p_keep + i_keep + d_keep);
    end
    r.drive  = 32'(clamp_to_limits(sum));
    r.prop   = 32'(p_keep);
    r.integ  = 32'(i_keep);
    r.deriv  = 32'(d_keep);
    r.held   = 1'b0;
    r.frozen = frz;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [31:0] w, logic [31:0] a);
    if (w == a) return 0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, w, a);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      kp = 0;
      ki = 0;
      kd = 0;
      lim_lo = pidaw_pkg::DRIVE_MIN_RST;
      lim_hi = pidaw_pkg::DRIVE_MAX_RST;
      acc = 0;
      prev_sensed = 0;
      p_keep = 0;
      i_keep = 0;
      d_keep = 0;
      have_seed = 1'b0;
      queued_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pidaw_pkg::REG_GAIN_PROP:  kp = $signed(cfg_wdata);
          pidaw_pkg::REG_GAIN_INTEG: ki = $signed(cfg_wdata);
          pidaw_pkg::REG_GAIN_DERIV: kd = $signed(cfg_wdata);
          pidaw_pkg::REG_DRIVE_MIN:  lim_lo = $signed(cfg_wdata);
          pidaw_pkg::REG_DRIVE_MAX:  lim_hi = $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.drive  = out_tdata[31:0];
        got.prop   = out_tdata[63:32];
        got.integ  = out_tdata[95:64];
        got.deriv  = out_tdata[127:96];
        got.held   = out_tuser[0];
        got.frozen = out_tuser[1];
        n_res++;
        n_held += got.held;
        n_frz += got.frozen;
        if (queued_drives.size() == 0) begin
          $display("%0t: result with none pending, expected nothing, actual %h %b",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = queued_drives.pop_front();
          errs += field_bad("drive", want.drive, got.drive);
          errs += field_bad("prop_part", want.prop, got.prop);
          errs += field_bad("integ_part", want.integ, got.integ);
          errs += field_bad("deriv_part", want.deriv, got.deriv);
          errs += field_bad("held", 32'(want.held), 32'(got.held));
          errs += field_bad("frozen", 32'(want.frozen), 32'(got.frozen));
        end
      end
      if (in_tvalid && in_tready) queued_drives.push_back(compute_drive(in_tdata));
    end
    mismatches   <= errs;
    outstanding  <= queued_drives.size();
    results_seen <= n_res;
    held_seen    <= n_held;
    frozen_seen  <= n_frz;
  end

endmodule

FILE: dv/tb_top.sv
// top of the pid controller testbench: stimulus, stream idling and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 305;
  localparam int Q_ONE           = 65536;   // 1.0 in Q16.16

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic [95:0]                        in_tdata = '0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [127:0]                       out_tdata;
  logic [1:0]                         out_tuser;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [pidaw_pkg::CFG_AW-1:0]       cfg_addr = '0;
  logic [pidaw_pkg::DATA_W-1:0]       cfg_wdata = '0;

  // status from the checker
  int mismatches, outstanding, results_seen, held_seen, frozen_seen;

  // idle rates in percent of cycles, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // a crude plant for well-formed loop traffic: setpoint and a measurement chasing it
  int setpoint = 0;
  int plant = 0;
  int settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_antiwindup_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pid_antiwindup_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .held_seen    (held_seen),
    .frozen_seen  (frozen_seen)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) out_tready <= (int'($urandom_range(99)) >= recv_idle_pct);

  // present one sample and hold it until the transaction happens
  task automatic send_sample(input logic [31:0] tgt, input logic [31:0] sen,
                             input logic [31:0] dt);
    // valid stays high across back-to-back samples, only dropped for a real gap
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {dt, sen, tgt};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic settle();
    in_tvalid <= 1'b0;
    // let the checker count include the last transaction before polling it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [pidaw_pkg::CFG_AW-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // write all five registers back to back, block must be idle
  task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] lo,
                            input logic [31:0] hi);
    put_reg(pidaw_pkg::REG_GAIN_PROP, kp);
    put_reg(pidaw_pkg::REG_GAIN_INTEG, ki);
    put_reg(pidaw_pkg::REG_GAIN_DERIV, kd);
    put_reg(pidaw_pkg::REG_DRIVE_MIN, lo);
    put_reg(pidaw_pkg::REG_DRIVE_MAX, hi);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly modest gains, with zero and both extremes mixed in
  function automatic logic [31:0] pick_gain();
    logic [31:0] g;
    case ($urandom_range(9))
      0: g = '0;
      1: g = 32'h7FFF_FFFF;
      2: g = 32'h8000_0000;
      3: g = $urandom();
      default: begin
        g = $urandom_range(4 * Q_ONE);
        if ($urandom_range(1)) g = -g;
      end
    endcase
    return g;
  endfunction

  task automatic pick_limits(output logic [31:0] lo, output logic [31:0] hi);
    case ($urandom_range(7))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        // inverted window
        lo = $urandom_range(1, 4 * Q_ONE);
        hi = -lo;
      end
      2: begin
        lo = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
        hi = lo;
      end
      3: begin
        lo = $urandom();
        hi = $urandom();
      end
      default: begin
        lo = -int'($urandom_range(Q_ONE / 4, 8 * Q_ONE));
        hi = $urandom_range(Q_ONE / 4, 8 * Q_ONE);
      end
    endcase
  endtask

  // mostly closed-loop samples, some holds and some raw noise
  task automatic random_sample();
    logic [31:0] tgt, sen, dt;
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      tgt = $urandom();
      sen = $urandom();
      dt  = $urandom_range(1) ? 32'd0 : {1'b1, 31'($urandom())};
    end else if (r < 18) begin
      tgt = $urandom();
      sen = $urandom();
      dt  = $urandom();
    end else begin
      if ($urandom_range(19) == 0) setpoint = int'($urandom_range(8 * Q_ONE)) - 4 * Q_ONE;
      plant = plant + (setpoint - plant) / 8 + int'($urandom_range(4000)) - 2000;
      tgt = setpoint;
      sen = plant;
      // typical loop periods are small, a few long ones
      dt = ($urandom_range(9) == 0) ? $urandom_range(1, 4 * Q_ONE) : $urandom_range(1, 6554);
    end
    send_sample(tgt, sen, dt);
  endtask

  initial begin
    logic [31:0] kp, ki, kd, lo, hi;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: hold before any active sample, then the seeding sample
    send_sample(0, 0, 0);
    send_sample(Q_ONE, 0, Q_ONE);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

    // ordinary gains, default window: saturation both ways, frozen integrator
    settle();
    load_gains(2 * Q_ONE, Q_ONE, Q_ONE / 2, -Q_ONE, Q_ONE);
    send_sample(0, 0, 6554);
    send_sample(3 * Q_ONE, 0, 6554);
    send_sample(-3 * Q_ONE, 0, 6554);
    // huge measurement jump over the shortest step, derivative saturates
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // holds re-emit the stored terms
    send_sample(0, 0, 0);
    send_sample(0, 0, 32'hFFFF_FFFF);
    send_sample(0, 0, 32'h8000_0000);

    // extreme gains, full-range window
    settle();
    load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(Q_ONE, 0, Q_ONE);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_sample(0, 0, 0);

    // inverted limits: min above max
    settle();
    load_gains(Q_ONE, Q_ONE, 0, Q_ONE, -Q_ONE);
    send_sample(0, 0, Q_ONE);
    send_sample(2 * Q_ONE, 0, Q_ONE);
    send_sample(-2 * Q_ONE, 0, Q_ONE);
    send_sample(0, 0, 0);

    // zero-width window with the opposite extreme gains
    settle();
    load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_sample(Q_ONE, 0, Q_ONE);
    send_sample(-Q_ONE, Q_ONE / 2, 100);

    // random phases, each under its own gains and window
    for (int p = 0; p < PHASES; p++) begin
      settle();
      kp = pick_gain();
      ki = pick_gain();
      kd = pick_gain();
      pick_limits(lo, hi);
      if (p == 1) begin
        kp = 32'h7FFF_FFFF;
        ki = 32'h7FFF_FFFF;
        kd = 32'h8000_0000;
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end else if (p == 3) begin
        lo = 2 * Q_ONE;
        hi = -2 * Q_ONE;
      end
      load_gains(kp, ki, kd, lo, hi);
      // receiver-heavy idling, then sender-heavy, then none
      case (p / 2)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then drain completely before the next sample
        if ($urandom_range(59) == 0) settle();
        random_sample();
      end
    end

    // drain and let the pipeline go quiet
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d samples (%0d held, %0d with the integrator frozen)",
             results_seen, held_seen, frozen_seen);
    $display("under %0d gain and limit settings, including extremes and inverted limits",
             settings_used);
    if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
